### rtl/dmqm_pkg.sv
// ----------------------------------------------------------------------------
// dmqm_pkg
// Shared types and constants of the depth map quad mesh emitter.
// ----------------------------------------------------------------------------
package dmqm_pkg;

  // Geometry limits and register widths
  localparam int CFG_DIM_W  = 11;
  localparam int ROW_W      = 10;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 2;
  localparam int PADDR_W    = 5;

  // Fixed point constants
  localparam logic [23:0] HALF_Q24 = 24'h80_0000;
  localparam logic [15:0] RND_Q16  = 16'h8000;
  localparam logic [24:0] POS_MAX  = 25'h0FF_FFFF;
  localparam logic [24:0] POS_MIN  = 25'h100_0000;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;

  // Index of the sixth vertex of a quad
  localparam logic [2:0] VTX_LAST = 3'd5;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_WIDTH      = 3'd0;
  localparam logic [2:0] REG_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_INV_WIDTH  = 3'd2;
  localparam logic [2:0] REG_INV_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COLOR_MIN  = 3'd4;
  localparam logic [2:0] REG_COLOR_GAIN = 3'd5;

  // Register reset values
  localparam logic [10:0] RST_WIDTH      = 11'd640;
  localparam logic [10:0] RST_HEIGHT     = 11'd480;
  localparam logic [23:0] RST_INV_WIDTH  = 24'd26214;
  localparam logic [23:0] RST_INV_HEIGHT = 24'd34953;
  localparam logic [7:0]  RST_COLOR_MIN  = 8'd0;
  localparam logic [15:0] RST_COLOR_GAIN = 16'd257;

  // Corner of the quad a vertex comes from
  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_TR,
    CORNER_BL,
    CORNER_BR
  } corner_e;

  // One stored pixel, red in the top byte, depth at the bottom
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] depth;
  } pixel_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [23:0] inv_width;
    logic [23:0] inv_height;
    logic [7:0]  color_min;
    logic [15:0] color_gain;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    clear;
    logic    store;
    logic    issue;
    corner_e corner;
    logic    last;
    logic    update;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quad;
    logic advance;
    logic clr_last;
  } sts_t;

endpackage

### rtl/dmqm_pixel_if.sv
// ----------------------------------------------------------------------------
// dmqm_pixel_if
// Pixel request channel: depth plus blue, green and red samples.
// ----------------------------------------------------------------------------
interface dmqm_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_in;
  logic [7:0]  blue_in;
  logic [7:0]  green_in;
  logic [7:0]  red_in;

  modport source (output valid, output depth_in, output blue_in, output green_in,
                  output red_in, input ready);
  modport sink   (input valid, input depth_in, input blue_in, input green_in,
                  input red_in, output ready);
endinterface

### rtl/dmqm_vertex_if.sv
// ----------------------------------------------------------------------------
// dmqm_vertex_if
// Vertex request channel: position, normalised colour and end of quad flag.
// ----------------------------------------------------------------------------
interface dmqm_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] pos_x;
  logic signed [24:0] pos_y;
  logic        [23:0] pos_z;
  logic        [15:0] red_out;
  logic        [15:0] green_out;
  logic        [15:0] blue_out;
  logic               quad_last;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output red_out, output green_out, output blue_out,
                  output quad_last, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input red_out, input green_out, input blue_out,
                  input quad_last, output ready);
endinterface

### rtl/depth_map_quad_mesh_emitter.sv
// ----------------------------------------------------------------------------
// depth_map_quad_mesh_emitter
// Turns a raster stream of depth and colour pixels into a triangle list.
// ----------------------------------------------------------------------------
// Pixels enter in raster order. Each pixel past the first row and column
// closes a 2x2 quad and yields six vertices (tl, tr, bl, bl, tr, br), the last
// flagged by quad_last. Such a pixel has its request taken, the pixel above
// looked up in the row store, then one vertex issued per cycle into a three
// stage pipeline; pixels in the first row or column stop after the lookup.
// The pace is set by the single vertex pipeline feeding the output register,
// and any stall on the vertex channel holds that pipeline and the issue
// sequence with it. After reset the row store is cleared one entry per cycle,
// all MAX_WIDTH entries (1024 by default), before the first pixel is taken;
// register writes are taken during that pass.
module depth_map_quad_mesh_emitter import dmqm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dmqm_pixel_if.sink         pix_i,
  dmqm_vertex_if.source      vtx_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t   cfg;
  cmd_t   cmd;
  sts_t   sts;
  pixel_t pix;
  logic   in_ready;

  assign pix = '{red: pix_i.red_in, green: pix_i.green_in, blue: pix_i.blue_in,
                 depth: pix_i.depth_in};
  assign pix_i.ready = in_ready;

  // Register file
  dmqm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer
  dmqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Row store and vertex pipeline
  dmqm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .pix_i  (pix),
    .vtx_o  (vtx_o)
  );

  // One pixel at a time: no new request right after one is taken
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> !pix_i.ready)
    else $error("pixel taken while previous one still in progress");

  // Vertices are only issued when the pipeline moves
  a_issue_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> sts.advance)
    else $error("vertex issued into a stalled pipeline");

  // No pixel is taken during the row store clear
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !pix_i.ready && !cmd.store)
    else $error("pixel traffic during row store clear");

endmodule

### rtl/dmqm_cfg.sv
// ----------------------------------------------------------------------------
// dmqm_cfg
// APB register file holding geometry, reciprocals and colour scaling.
// ----------------------------------------------------------------------------
module dmqm_cfg import dmqm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic       wr_en;
  logic [2:0] idx;
  cfg_t       cfg_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= RST_WIDTH;
      cfg_q.image_height <= RST_HEIGHT;
      cfg_q.inv_width    <= RST_INV_WIDTH;
      cfg_q.inv_height   <= RST_INV_HEIGHT;
      cfg_q.color_min    <= RST_COLOR_MIN;
      cfg_q.color_gain   <= RST_COLOR_GAIN;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:      cfg_q.image_width  <= pwdata[10:0];
        REG_HEIGHT:     cfg_q.image_height <= pwdata[10:0];
        REG_INV_WIDTH:  cfg_q.inv_width    <= pwdata[23:0];
        REG_INV_HEIGHT: cfg_q.inv_height   <= pwdata[23:0];
        REG_COLOR_MIN:  cfg_q.color_min    <= pwdata[7:0];
        REG_COLOR_GAIN: cfg_q.color_gain   <= pwdata[15:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (idx)
      REG_WIDTH:      prdata = {21'd0, cfg_q.image_width};
      REG_HEIGHT:     prdata = {21'd0, cfg_q.image_height};
      REG_INV_WIDTH:  prdata = {8'd0, cfg_q.inv_width};
      REG_INV_HEIGHT: prdata = {8'd0, cfg_q.inv_height};
      REG_COLOR_MIN:  prdata = {24'd0, cfg_q.color_min};
      REG_COLOR_GAIN: prdata = {16'd0, cfg_q.color_gain};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/dmqm_ctrl.sv
// ----------------------------------------------------------------------------
// dmqm_ctrl
// Sequencer: clears the row store, takes a pixel, looks up the pixel above
// and issues the six vertices of a closed quad.
// ----------------------------------------------------------------------------
module dmqm_ctrl import dmqm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] vtx_q, vtx_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    vtx_d         = vtx_q;
    cmd_o         = '0;
    cmd_o.corner  = CORNER_TL;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.store = 1'b1;
        vtx_d       = '0;
        if (sts_i.quad) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // vertex order tl, tr, bl, bl, tr, br
        case (vtx_q)
          3'd0:    cmd_o.corner = CORNER_TL;
          3'd1:    cmd_o.corner = CORNER_TR;
          3'd2:    cmd_o.corner = CORNER_BL;
          3'd3:    cmd_o.corner = CORNER_BL;
          3'd4:    cmd_o.corner = CORNER_TR;
          default: cmd_o.corner = CORNER_BR;
        endcase
        if (sts_i.advance) begin
          cmd_o.issue = 1'b1;
          cmd_o.last  = (vtx_q == VTX_LAST);
          if (vtx_q == VTX_LAST) begin
            cmd_o.update = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            vtx_d = vtx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      vtx_q   <= '0;
    end else begin
      state_q <= state_d;
      vtx_q   <= vtx_d;
    end
  end

endmodule

### rtl/dmqm_datapath.sv
// ----------------------------------------------------------------------------
// dmqm_datapath
// Row store, pixel registers, column and row counters and the three stage
// vertex pipeline ending in the output register.
// ----------------------------------------------------------------------------
module dmqm_datapath import dmqm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  cmd_t   cmd_i,
  output sts_t   sts_o,
  input  pixel_t pix_i,
  dmqm_vertex_if.source vtx_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > CFG_DIM_W) ? AW + 1 : CFG_DIM_W;
  localparam int IW = (AW > ROW_W) ? AW : ROW_W;
  localparam int DW = IW + 25;  // signed u - 0.5 in Q.24
  localparam int HW = DW - 17;  // upper slice of that
  localparam int PW = DW + 17;  // full product plus rounding
  localparam int QW = PW - 16;

  // Depth times (u - 0.5), rounded half up to Q.16 and saturated to 25 bits
  function automatic logic [24:0] round_sat(input logic signed [HW+16:0] ph,
                                            input logic [32:0] pl);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] p;
    logic        [QW-1:0] q;
    hi = PW'(ph);
    hi = hi <<< 17;
    lo = $signed(PW'(pl));
    p  = hi + lo + $signed(PW'(RND_Q16));
    q  = p[PW-1:16];
    if ((&q[QW-1:24]) || !(|q[QW-1:24])) round_sat = q[24:0];
    else if (q[QW-1])                    round_sat = POS_MIN;
    else                                 round_sat = POS_MAX;
  endfunction

  function automatic logic [7:0] sub_floor(input logic [7:0] c, input logic [7:0] m);
    sub_floor = (c < m) ? 8'd0 : c - m;
  endfunction

  function automatic logic [15:0] sat16(input logic [23:0] v);
    sat16 = (|v[23:16]) ? COL_MAX : v[15:0];
  endfunction

  // ---------------- row store and pixel state ----------------
  pixel_t        mem [MAX_WIDTH];
  pixel_t        rd_q, cur_q, left_q, ul_q;
  logic [AW-1:0] col_q, clr_q;
  logic [ROW_W-1:0] row_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pixel_t        mem_wdata;

  assign mem_we    = cmd_i.clear || cmd_i.store;
  assign mem_waddr = cmd_i.clear ? clr_q : col_q;
  assign mem_wdata = cmd_i.clear ? '0 : cur_q;

  // Line store: one write port, registered read of the pixel above
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.accept) rd_q <= mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cur_q <= pix_i;
  end

  // Effective geometry
  logic [CW-1:0]        w_raw, w_eff, col_nx;
  logic [CFG_DIM_W-1:0] h_eff, row_nx;

  assign w_raw  = CW'(cfg_i.image_width);
  assign col_nx = CW'(col_q) + CW'(1);
  assign row_nx = CFG_DIM_W'(row_q) + CFG_DIM_W'(1);

  always_comb begin
    if (w_raw < CW'(MIN_DIM))        w_eff = CW'(MIN_DIM);
    else if (w_raw > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else                             w_eff = w_raw;
    if (cfg_i.image_height < CFG_DIM_W'(MIN_DIM))         h_eff = CFG_DIM_W'(MIN_DIM);
    else if (cfg_i.image_height > CFG_DIM_W'(MAX_HEIGHT)) h_eff = CFG_DIM_W'(MAX_HEIGHT);
    else                                                  h_eff = cfg_i.image_height;
  end

  // Counters, neighbours and clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      clr_q  <= '0;
      left_q <= '0;
      ul_q   <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
      if (cmd_i.update) begin
        ul_q   <= rd_q;
        left_q <= cur_q;
        if (col_nx >= w_eff) begin
          col_q <= '0;
          if (row_nx >= h_eff) row_q <= '0;
          else                 row_q <= row_nx[ROW_W-1:0];
        end else begin
          col_q <= col_nx[AW-1:0];
        end
      end
    end
  end

  // ---------------- vertex pipeline ----------------
  logic a_v_q, b_v_q, o_v_q, en;

  assign en                = !o_v_q || vtx_o.ready;
  assign sts_o.advance     = en;
  assign sts_o.quad        = (col_q != '0) && (row_q != '0);
  assign sts_o.clr_last    = (clr_q == AW'(MAX_WIDTH - 1));

  // Stage A: pick the corner and scale its indices
  pixel_t           sel_pix;
  logic [IW-1:0]    ci, ri;
  logic [IW+23:0]   ax_d, ay_d;

  always_comb begin
    case (cmd_i.corner)
      CORNER_TL: begin
        sel_pix = ul_q;   ci = IW'(col_q - AW'(1)); ri = IW'(row_q - ROW_W'(1));
      end
      CORNER_TR: begin
        sel_pix = rd_q;   ci = IW'(col_q);          ri = IW'(row_q - ROW_W'(1));
      end
      CORNER_BL: begin
        sel_pix = left_q; ci = IW'(col_q - AW'(1)); ri = IW'(row_q);
      end
      default: begin
        sel_pix = cur_q;  ci = IW'(col_q);          ri = IW'(row_q);
      end
    endcase
  end

  assign ax_d = ci * cfg_i.inv_width;
  assign ay_d = ri * cfg_i.inv_height;

  logic [IW+23:0] ax_q, ay_q;
  logic [15:0]    a_dep_q;
  logic [7:0]     a_r_q, a_g_q, a_b_q;
  logic           a_last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      a_dep_q  <= sel_pix.depth;
      a_r_q    <= sub_floor(sel_pix.red, cfg_i.color_min);
      a_g_q    <= sub_floor(sel_pix.green, cfg_i.color_min);
      a_b_q    <= sub_floor(sel_pix.blue, cfg_i.color_min);
      a_last_q <= cmd_i.last;
    end
  end

  // Stage B: centre the coordinates, split products, colour gain
  logic signed [DW-1:0]   dx, dy;
  logic signed [HW-1:0]   dxh, dyh;
  logic        [16:0]     dxl, dyl;
  logic signed [HW+16:0]  pxh_d, pyh_d;
  logic        [32:0]     pxl_d, pyl_d;

  assign dx    = {1'b0, ax_q} - DW'(HALF_Q24);
  assign dy    = {1'b0, ay_q} - DW'(HALF_Q24);
  assign dxh   = dx[DW-1:17];
  assign dyh   = dy[DW-1:17];
  assign dxl   = dx[16:0];
  assign dyl   = dy[16:0];
  assign pxh_d = $signed({1'b0, a_dep_q}) * dxh;
  assign pyh_d = $signed({1'b0, a_dep_q}) * dyh;
  assign pxl_d = a_dep_q * dxl;
  assign pyl_d = a_dep_q * dyl;

  logic signed [HW+16:0] pxh_q, pyh_q;
  logic        [32:0]    pxl_q, pyl_q;
  logic        [23:0]    cr_q, cg_q, cb_q;
  logic        [15:0]    b_dep_q;
  logic                  b_last_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxh_q    <= pxh_d;
      pyh_q    <= pyh_d;
      pxl_q    <= pxl_d;
      pyl_q    <= pyl_d;
      cr_q     <= a_r_q * cfg_i.color_gain;
      cg_q     <= a_g_q * cfg_i.color_gain;
      cb_q     <= a_b_q * cfg_i.color_gain;
      b_dep_q  <= a_dep_q;
      b_last_q <= a_last_q;
    end
  end

  // Stage C: round, saturate, output register
  logic [24:0] ox_q, oy_q;
  logic [23:0] oz_q;
  logic [15:0] or_q, og_q, ob_q;
  logic        olast_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q    <= round_sat(pxh_q, pxl_q);
      oy_q    <= round_sat(pyh_q, pyl_q);
      oz_q    <= {b_dep_q, 8'h00};
      or_q    <= sat16(cr_q);
      og_q    <= sat16(cg_q);
      ob_q    <= sat16(cb_q);
      olast_q <= b_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= cmd_i.issue;
      b_v_q <= a_v_q;
      o_v_q <= b_v_q;
    end
  end

  assign vtx_o.valid     = o_v_q;
  assign vtx_o.pos_x     = ox_q;
  assign vtx_o.pos_y     = oy_q;
  assign vtx_o.pos_z     = oz_q;
  assign vtx_o.red_out   = or_q;
  assign vtx_o.green_out = og_q;
  assign vtx_o.blue_out  = ob_q;
  assign vtx_o.quad_last = olast_q;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth map quad mesh emitter. Pixel requests go in
// through random gaps, vertex requests come out under random back-pressure, and
// every vertex is compared field by field against a behavioural predictor of
// the quad walk, the fixed point projection and the colour scaling. Geometry and
// colour registers are swept across phases over the APB-style port.
// ----------------------------------------------------------------------------
module tb_top import dmqm_pkg::*; ();

  localparam int          LINE_DEPTH   = 1024;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 300;
  // Addresses past the register list; writes there must be ignored
  localparam logic [2:0]  REG_SPARE_A  = 3'd6;
  localparam logic [2:0]  REG_SPARE_B  = 3'd7;
  localparam logic [23:0] INV_ONE_HALF = 24'd8388608;

  // One vertex as seen on the output channel
  typedef struct packed {
    logic [24:0] pos_x;
    logic [24:0] pos_y;
    logic [23:0] pos_z;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        quad_last;
  } vertex_t;

  // --------------------------------------------------------------------------
  // Quad mesh predictor and store of expected vertices
  // --------------------------------------------------------------------------
  class mesh_scoreboard;
    pixel_t      line_mem [LINE_DEPTH];
    pixel_t      left_px;
    pixel_t      upleft_px;
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [10:0] img_w;
    logic [10:0] img_h;
    logic [23:0] inv_w;
    logic [23:0] inv_h;
    logic [7:0]  c_min;
    logic [15:0] c_gain;
    vertex_t     vertex_q [$];
    int          errors;
    int          pixels_seen;
    int          vertices_seen;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      left_px       = '0;
      upleft_px     = '0;
      col_cnt       = 0;
      row_cnt       = 0;
      img_w         = RST_WIDTH;
      img_h         = RST_HEIGHT;
      inv_w         = RST_INV_WIDTH;
      inv_h         = RST_INV_HEIGHT;
      c_min         = RST_COLOR_MIN;
      c_gain        = RST_COLOR_GAIN;
      errors        = 0;
      pixels_seen   = 0;
      vertices_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_WIDTH:      img_w  = val[10:0];
        REG_HEIGHT:     img_h  = val[10:0];
        REG_INV_WIDTH:  inv_w  = val[23:0];
        REG_INV_HEIGHT: inv_h  = val[23:0];
        REG_COLOR_MIN:  c_min  = val[7:0];
        REG_COLOR_GAIN: c_gain = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return vertex_q.size();
    endfunction

    // Append one expected vertex at the tail of the queue
    function void add_vertex(vertex_t v);
      vertex_q = {vertex_q, v};
    endfunction

    // depth (Q8.8) times (index*inv - 0.5) (Q.24), rounded half up to Q.16
    function logic [24:0] project(logic [15:0] depth, int unsigned index,
                                  logic [23:0] inv);
      longint offs;
      longint prod;
      longint res;
      offs = longint'(index) * longint'(inv) - longint'(HALF_Q24);
      prod = longint'(depth) * offs + longint'(RND_Q16);
      res  = prod >>> 16;
      if (res > longint'(POS_MAX)) res = longint'(POS_MAX);
      if (res < longint'($signed(POS_MIN))) res = longint'($signed(POS_MIN));
      return res[24:0];
    endfunction

    function logic [15:0] shade(logic [7:0] sample);
      int unsigned diff;
      int unsigned prod;
      if (sample < c_min) return '0;
      diff = sample - c_min;
      prod = diff * c_gain;
      return (prod > 32'(COL_MAX)) ? COL_MAX : prod[15:0];
    endfunction

    function vertex_t corner_vertex(int unsigned col, int unsigned row, pixel_t px,
                                    bit last);
      vertex_t v;
      v.pos_x     = project(px.depth, col, inv_w);
      v.pos_y     = project(px.depth, row, inv_h);
      v.pos_z     = {px.depth, 8'h00};
      v.red_out   = shade(px.red);
      v.green_out = shade(px.green);
      v.blue_out  = shade(px.blue);
      v.quad_last = last;
      return v;
    endfunction

    // Accepted pixel: emit the quad it closes, then advance the raster position
    function void note_pixel(pixel_t cur);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      pixel_t      above;
      w = img_w;
      h = img_h;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h < MIN_DIM) h = MIN_DIM;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      idx   = (col_cnt < LINE_DEPTH) ? col_cnt : LINE_DEPTH - 1;
      above = line_mem[idx];
      if (col_cnt >= 1 && row_cnt >= 1) begin
        add_vertex(corner_vertex(col_cnt - 1, row_cnt - 1, upleft_px, 1'b0));
        add_vertex(corner_vertex(col_cnt, row_cnt - 1, above, 1'b0));
        add_vertex(corner_vertex(col_cnt - 1, row_cnt, left_px, 1'b0));
        add_vertex(corner_vertex(col_cnt - 1, row_cnt, left_px, 1'b0));
        add_vertex(corner_vertex(col_cnt, row_cnt - 1, above, 1'b0));
        add_vertex(corner_vertex(col_cnt, row_cnt, cur, 1'b1));
      end
      upleft_px     = above;
      left_px       = cur;
      line_mem[idx] = cur;
      pixels_seen++;
      // Counters wrap on any count at or past the effective geometry
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function bit field_differs(string name, longint expv, longint gotv);
      if (expv == gotv) return 1'b0;
      $error("%s mismatch: expected %0d, got %0d", name, expv, gotv);
      return 1'b1;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      bit      bad;
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        $error("vertex with no pending expectation: x %0d y %0d z %0d",
               $signed(got.pos_x), $signed(got.pos_y), got.pos_z);
        errors++;
        return;
      end
      exp_v = vertex_q.pop_front();
      bad   = 1'b0;
      bad  |= field_differs("pos_x", $signed(exp_v.pos_x), $signed(got.pos_x));
      bad  |= field_differs("pos_y", $signed(exp_v.pos_y), $signed(got.pos_y));
      bad  |= field_differs("pos_z", exp_v.pos_z, got.pos_z);
      bad  |= field_differs("red_out", exp_v.red_out, got.red_out);
      bad  |= field_differs("green_out", exp_v.green_out, got.green_out);
      bad  |= field_differs("blue_out", exp_v.blue_out, got.blue_out);
      bad  |= field_differs("quad_last", exp_v.quad_last, got.quad_last);
      if (bad) errors++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  dmqm_pixel_if  pix_if ();
  dmqm_vertex_if vtx_if ();

  mesh_scoreboard sb = new();

  bit hold_request  = 1'b0;
  bit sender_steady = 1'b0;
  int settings_done = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  depth_map_quad_mesh_emitter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .vtx_o   (vtx_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Random gap lengths: mostly short, a few long
  // --------------------------------------------------------------------------
  function automatic int send_gap();
    int pick;
    if (sender_steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Pixel contents
  // --------------------------------------------------------------------------
  // Depth extremes and samples just around a colour minimum of 100
  function automatic pixel_t directed_pixel(int k);
    pixel_t px;
    case (k % 4)
      0:       px.depth = 16'h0000;
      1:       px.depth = 16'hFFFF;
      2:       px.depth = 16'h8000;
      default: px.depth = 16'h00FF;
    endcase
    px.red   = (k % 3 == 0) ? 8'hFF : 8'h80;
    px.green = (k % 2 == 0) ? 8'h00 : 8'hFF;
    px.blue  = 8'(99 + k % 3);
    return px;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(0, 7))
      0:       px.depth = 16'h0000;
      1:       px.depth = 16'hFFFF;
      default: px.depth = 16'($urandom);
    endcase
    px.red   = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue  = 8'($urandom_range(0, 255));
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers; each task is entered just after a rising edge
  // --------------------------------------------------------------------------
  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [10:0] w, logic [10:0] h, logic [23:0] iw,
                           logic [23:0] ih, logic [7:0] cmin, logic [15:0] gain);
    apb_write(REG_WIDTH, 32'(w));
    apb_write(REG_HEIGHT, 32'(h));
    apb_write(REG_INV_WIDTH, 32'(iw));
    apb_write(REG_INV_HEIGHT, 32'(ih));
    apb_write(REG_COLOR_MIN, 32'(cmin));
    apb_write(REG_COLOR_GAIN, 32'(gain));
    settings_done++;
  endtask

  // valid stays high across back-to-back requests
  task automatic send_pixel(pixel_t px, int gap);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.depth_in <= px.depth;
    pix_if.blue_in  <= px.blue;
    pix_if.green_in <= px.green;
    pix_if.red_in   <= px.red;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    sb.note_pixel(px);
  endtask

  task automatic send_pixels(int n, bit directed);
    for (int k = 0; k < n; k++)
      send_pixel(directed ? directed_pixel(k) : random_pixel(), send_gap());
  endtask

  // Drain all vertices, then let a trailing no-quad pixel finish
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [10:0] w, logic [10:0] h, logic [23:0] iw,
                           logic [23:0] ih, logic [7:0] cmin, logic [15:0] gain,
                           int n, bit hold);
    wait_idle();
    configure(w, h, iw, ih, cmin, gain);
    sender_steady = ($urandom_range(0, 3) == 0);
    if (hold) hold_request = 1'b1;
    send_pixels(n, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Vertex receiver: checks each request and paces ready
  // --------------------------------------------------------------------------
  initial begin : vertex_sink
    vertex_t got;
    int      stall_left;
    int      hold_left;
    bit      steady;
    bit      rdy;
    stall_left = 0;
    hold_left  = 0;
    steady     = 1'b0;
    vtx_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (vtx_if.valid && vtx_if.ready) begin
        got = '{vtx_if.pos_x, vtx_if.pos_y, vtx_if.pos_z, vtx_if.red_out,
                vtx_if.green_out, vtx_if.blue_out, vtx_if.quad_last};
        sb.check_vertex(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if ($urandom_range(0, 249) == 0) steady = !steady;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = stall_len();
      end
      vtx_if.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int waited;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_if.valid    <= 1'b0;
    pix_if.depth_in <= '0;
    pix_if.blue_in  <= '0;
    pix_if.green_in <= '0;
    pix_if.red_in   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 5x3 frame, column scale of one half so wide columns saturate,
    // zero row scale, samples around the colour minimum; the tail of the run
    // starts a new frame whose first row emits nothing
    configure(11'd5, 11'd3, INV_ONE_HALF, 24'd0, 8'd100, 16'd600);
    apb_write(REG_SPARE_A, 32'hFFFF_FFFF);
    apb_write(REG_SPARE_B, 32'h0000_0001);
    send_pixels(20, 1'b1);

    // Smallest frame, zero gain
    run_phase(11'd2, 11'd2, 24'($urandom_range(0, 8388608)),
              24'($urandom_range(0, 8388608)), 8'd0, 16'd0, 40, 1'b0);
    // Geometry below range acts as 2x2; colour extremes
    run_phase(11'd0, 11'd1, 24'd0, INV_ONE_HALF, 8'd255, 16'd65535, 30, 1'b0);
    // Geometry above range: a partial first row only
    run_phase(11'd2047, 11'd2047, 24'($urandom_range(0, 8388608)),
              24'($urandom_range(0, 8388608)), 8'($urandom_range(0, 255)),
              16'($urandom), 25, 1'b0);
    // Shrink the geometry mid-frame: the column count wraps on the next pixel
    run_phase(11'd4, 11'd3, 24'd4194304, 24'd5592405, 8'($urandom_range(0, 255)),
              16'($urandom), 60, 1'b0);
    run_phase(11'd7, 11'd5, 24'd2396745, 24'd3355443, 8'($urandom_range(0, 64)),
              16'($urandom_range(0, 1024)), 80, 1'b0);
    // Long output hold while pixels keep coming
    run_phase(11'd33, 11'd4, 24'd508400, 24'($urandom_range(0, 8388608)),
              8'($urandom_range(0, 255)), 16'($urandom), 100, 1'b1);
    run_phase(11'($urandom_range(2, 16)), 11'($urandom_range(2, 6)),
              24'($urandom_range(0, 8388608)), 24'($urandom_range(0, 8388608)),
              8'($urandom_range(0, 255)), 16'($urandom), 100, 1'b0);

    // Drain, with a bound, then watch for stray vertices
    pix_if.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected vertices never arrived", sb.pending());
      sb.errors++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d pixels and %0d vertices over %0d register settings,",
             sb.pixels_seen, sb.vertices_seen, settings_done);
    $display("including out-of-range geometry, a mid-frame resize and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
